// ===== sv/rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared types and constants for the rotor mixer column core.
// ----------------------------------------------------------------------------
package rmc_pkg;

    localparam int NUM_COORDS  = 6;
    localparam int CORDIC_N    = 24;
    localparam int IN_TDATA_W  = 280;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 4;

    typedef logic [5:0] t_coord_en;

    typedef struct packed {
        logic        [3:0]  motor_index;
        logic        [31:0] kv;
        logic        [31:0] supply_voltage;
        logic        [15:0] full_scale;
        logic signed [15:0] tilt_angle;
        logic signed [15:0] azimuth_angle;
        logic signed [31:0] thrust_coef;
        logic signed [31:0] drag_coef;
        logic               spin_positive;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_item;

    typedef struct packed {
        logic        [3:0]  column;
        logic        [2:0]  row;
        logic        [2:0]  coordinate;
        logic signed [31:0] coefficient;
        logic               saturated;
        logic               last;
    } t_result;

    // arctan(2^-i) in Q2.30
    localparam logic [29:0] C_ATAN [CORDIC_N] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    localparam logic signed [33:0] C_PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] C_HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] C_GAIN_Q30    = 34'sd652032874;

endpackage

// ===== sv/rmc_front.sv =====
// ----------------------------------------------------------------------------
// rmc_front
// Accepts motor items, drops those that yield no rows, queues the rest.
// ----------------------------------------------------------------------------
module rmc_front #(
    parameter int MAX_MOTORS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rmc_pkg::t_coord_en                 i_coord_en,
    input  logic                               i_valid,
    input  logic [rmc_pkg::IN_TDATA_W-1:0]     i_data,
    output logic                               o_ready,
    output logic                               o_valid,
    output rmc_pkg::t_item                     o_item,
    input  logic                               i_pop
);
    import rmc_pkg::*;

    t_item      w_item;
    logic       w_keep;
    logic       w_push;
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_comb begin
        w_item.motor_index    = i_data[3:0];
        w_item.kv             = i_data[35:4];
        w_item.supply_voltage = i_data[67:36];
        w_item.full_scale     = i_data[83:68];
        w_item.tilt_angle     = i_data[99:84];
        w_item.azimuth_angle  = i_data[115:100];
        w_item.thrust_coef    = i_data[147:116];
        w_item.drag_coef      = i_data[179:148];
        w_item.spin_positive  = i_data[180];
        w_item.pos_x          = i_data[212:181];
        w_item.pos_y          = i_data[244:213];
        w_item.pos_z          = i_data[276:245];
    end

    // column out of range or nothing enabled: no rows, drop the beat
    assign w_keep  = (32'(w_item.motor_index) < 32'(MAX_MOTORS)) && (i_coord_en != '0);
    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready && w_keep;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop && o_valid);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !w_push) else $error("push into full queue");

endmodule

// ===== sv/rmc_back.sv =====
// ----------------------------------------------------------------------------
// rmc_back
// Sequencer: R by divider, sin/cos by cordic, products on one multiplier,
// then emits enabled rows through an output register.
// ----------------------------------------------------------------------------
module rmc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rmc_pkg::t_coord_en i_coord_en,
    input  logic               i_valid,
    input  rmc_pkg::t_item     i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    output rmc_pkg::t_result   o_out,
    input  logic               i_out_ready
);
    import rmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_KV, S_KVW, S_DIV, S_RSAT, S_CINIT, S_CORD, S_CFIN,
        S_MUL, S_MULW, S_EMIT
    } t_state;

    t_state              r_state;
    t_item               r_it;
    logic signed [65:0]  r_prod;
    logic [47:0]         r_dvd;
    logic [15:0]         r_rem;
    logic [5:0]          r_cnt;
    logic signed [33:0]  r_cx, r_cy, r_cz;
    logic                r_neg;
    logic                r_cph;
    logic [4:0]          r_ci;
    logic [4:0]          r_step;
    logic [2:0]          r_k;
    logic [2:0]          r_row;
    logic                r_fs, r_f3, r_f4, r_f5;
    logic signed [31:0]  r_r, r_r2, r_st, r_ct, r_sp, r_cp, r_rx, r_ry;
    logic signed [31:0]  r_tr2, r_cr2, r_tx, r_ty, r_tz, r_cx2, r_cy2, r_cz2;
    logic signed [31:0]  r_ma, r_mb, r_mc, r_md, r_me, r_mf;
    logic                r_ov;
    t_result             r_out;

    logic signed [32:0]  n_a, n_b;
    logic signed [49:0]  n_mq;
    logic signed [31:0]  n_mval;
    logic                n_msat;
    logic [16:0]         n_rsh;
    logic                n_ge;
    logic signed [33:0]  n_z0, n_dx, n_dy, n_at;
    logic signed [20:0]  n_xo, n_yo;
    logic signed [33:0]  n_sum;
    logic signed [31:0]  n_val;
    logic                n_vsat;
    logic                n_flag;
    logic [5:0]          n_hi;
    logic                n_en;
    logic                n_take;
    logic                n_load;

    // operand select for the shared multiplier
    always_comb begin
        n_a = {1'b0, r_it.kv};
        n_b = {1'b0, r_it.supply_voltage};
        if (r_state != S_KV) begin
            case (r_step)
                5'd0:    begin n_a = 33'(r_r);   n_b = 33'(r_r);   end
                5'd1:    begin n_a = 33'(r_cp);  n_b = 33'(r_st);  end
                5'd2:    begin n_a = 33'(r_sp);  n_b = 33'(r_st);  end
                5'd3:    begin n_a = 33'(r_it.thrust_coef); n_b = 33'(r_r2); end
                5'd4:    begin n_a = 33'(r_it.drag_coef);   n_b = 33'(r_r2); end
                5'd5:    begin n_a = 33'(r_rx);  n_b = 33'(r_tr2); end
                5'd6:    begin n_a = 33'(r_ry);  n_b = 33'(r_tr2); end
                5'd7:    begin n_a = 33'(r_ct);  n_b = 33'(r_tr2); end
                5'd8:    begin n_a = 33'(r_rx);  n_b = 33'(r_cr2); end
                5'd9:    begin n_a = 33'(r_ry);  n_b = 33'(r_cr2); end
                5'd10:   begin n_a = 33'(r_ct);  n_b = 33'(r_cr2); end
                5'd11:   begin n_a = 33'(r_it.pos_y); n_b = 33'(r_tz); end
                5'd12:   begin n_a = 33'(r_it.pos_z); n_b = 33'(r_ty); end
                5'd13:   begin n_a = 33'(r_it.pos_z); n_b = 33'(r_tx); end
                5'd14:   begin n_a = 33'(r_it.pos_x); n_b = 33'(r_tz); end
                5'd15:   begin n_a = 33'(r_it.pos_x); n_b = 33'(r_ty); end
                default: begin n_a = 33'(r_it.pos_y); n_b = 33'(r_tx); end
            endcase
        end
    end

    // floor shift by 16 and saturate
    always_comb begin
        n_mq   = r_prod[65:16];
        n_msat = (n_mq > 50'sd2147483647) || (n_mq < -50'sd2147483648);
        if (n_mq > 50'sd2147483647) begin
            n_mval = 32'sh7fffffff;
        end else if (n_mq < -50'sd2147483648) begin
            n_mval = -32'sh80000000;
        end else begin
            n_mval = n_mq[31:0];
        end
    end

    // restoring divider step
    assign n_rsh = {r_rem, r_dvd[47]};
    assign n_ge  = (n_rsh >= {1'b0, r_it.full_scale});

    // cordic
    assign n_z0 = 34'(r_cph ? r_it.azimuth_angle : r_it.tilt_angle) <<< 17;
    assign n_dx = r_cy >>> r_ci;
    assign n_dy = r_cx >>> r_ci;
    assign n_at = 34'(C_ATAN[r_ci]);
    assign n_xo = r_neg ? -21'(r_cx >>> 14) : 21'(r_cx >>> 14);
    assign n_yo = r_neg ? -21'(r_cy >>> 14) : 21'(r_cy >>> 14);

    // row value
    always_comb begin
        n_sum = '0;
        case (r_k)
            3'd3:    n_sum = (r_it.spin_positive ? -34'(r_cx2) : 34'(r_cx2))
                             + 34'(r_ma) - 34'(r_mb);
            3'd4:    n_sum = (r_it.spin_positive ? 34'(r_cy2) : -34'(r_cy2))
                             + 34'(r_mc) - 34'(r_md);
            default: n_sum = (r_it.spin_positive ? -34'(r_cz2) : 34'(r_cz2))
                             + 34'(r_me) - 34'(r_mf);
        endcase
        n_vsat = (n_sum > 34'sd2147483647) || (n_sum < -34'sd2147483648);
        if (n_sum > 34'sd2147483647) begin
            n_val = 32'sh7fffffff;
        end else if (n_sum < -34'sd2147483648) begin
            n_val = -32'sh80000000;
        end else begin
            n_val = n_sum[31:0];
        end
        n_flag = r_fs;
        case (r_k)
            3'd0: n_val = r_tx;
            3'd1: n_val = r_ty;
            3'd2: n_val = r_tz;
            3'd3: n_flag = r_fs | r_f3 | n_vsat;
            3'd4: n_flag = r_fs | r_f4 | n_vsat;
            default: n_flag = r_fs | r_f5 | n_vsat;
        endcase
    end

    assign n_hi   = i_coord_en >> r_k;
    assign n_en   = n_hi[0];
    assign n_take = !r_ov || i_out_ready;
    assign n_load = (r_state == S_EMIT) && n_en && n_take;
    assign o_pop  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (n_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_it    <= i_item;
                        r_fs    <= 1'b0;
                        r_f3    <= 1'b0;
                        r_f4    <= 1'b0;
                        r_f5    <= 1'b0;
                        r_state <= S_KV;
                    end
                end
                S_KV: begin
                    r_prod  <= n_a * n_b;
                    r_state <= S_KVW;
                end
                S_KVW: begin
                    r_dvd   <= r_prod[63:16];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_ge ? 16'(n_rsh - {1'b0, r_it.full_scale}) : n_rsh[15:0];
                    r_dvd <= {r_dvd[46:0], n_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) begin
                        r_state <= S_RSAT;
                    end
                end
                S_RSAT: begin
                    // zero divisor gives all ones and lands here too
                    if (r_dvd[47:31] != '0) begin
                        r_r  <= 32'sh7fffffff;
                        r_fs <= 1'b1;
                    end else begin
                        r_r <= r_dvd[31:0];
                    end
                    r_cph   <= 1'b0;
                    r_state <= S_CINIT;
                end
                S_CINIT: begin
                    r_cx <= C_GAIN_Q30;
                    r_cy <= '0;
                    r_ci <= '0;
                    if (n_z0 > C_HALF_PI_Q30) begin
                        r_cz  <= n_z0 - C_PI_Q30;
                        r_neg <= 1'b1;
                    end else if (n_z0 < -C_HALF_PI_Q30) begin
                        r_cz  <= n_z0 + C_PI_Q30;
                        r_neg <= 1'b1;
                    end else begin
                        r_cz  <= n_z0;
                        r_neg <= 1'b0;
                    end
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - n_dx;
                        r_cy <= r_cy + n_dy;
                        r_cz <= r_cz - n_at;
                    end else begin
                        r_cx <= r_cx + n_dx;
                        r_cy <= r_cy - n_dy;
                        r_cz <= r_cz + n_at;
                    end
                    r_ci <= r_ci + 5'd1;
                    if (r_ci == 5'(CORDIC_N - 1)) begin
                        r_state <= S_CFIN;
                    end
                end
                S_CFIN: begin
                    if (!r_cph) begin
                        r_st    <= 32'(n_yo);
                        r_ct    <= 32'(n_xo);
                        r_cph   <= 1'b1;
                        r_state <= S_CINIT;
                    end else begin
                        r_sp    <= 32'(n_yo);
                        r_cp    <= 32'(n_xo);
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= n_a * n_b;
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    case (r_step)
                        5'd0:    r_r2  <= n_mval;
                        5'd1:    r_rx  <= n_mval;
                        5'd2:    r_ry  <= n_mval;
                        5'd3:    r_tr2 <= n_mval;
                        5'd4:    r_cr2 <= n_mval;
                        5'd5:    r_tx  <= n_mval;
                        5'd6:    r_ty  <= n_mval;
                        5'd7:    r_tz  <= n_mval;
                        5'd8:    r_cx2 <= n_mval;
                        5'd9:    r_cy2 <= n_mval;
                        5'd10:   r_cz2 <= n_mval;
                        5'd11:   r_ma  <= n_mval;
                        5'd12:   r_mb  <= n_mval;
                        5'd13:   r_mc  <= n_mval;
                        5'd14:   r_md  <= n_mval;
                        5'd15:   r_me  <= n_mval;
                        default: r_mf  <= n_mval;
                    endcase
                    if (n_msat) begin
                        if (r_step <= 5'd10) begin
                            r_fs <= 1'b1;
                        end else if (r_step <= 5'd12) begin
                            r_f3 <= 1'b1;
                        end else if (r_step <= 5'd14) begin
                            r_f4 <= 1'b1;
                        end else begin
                            r_f5 <= 1'b1;
                        end
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd16) begin
                        r_k     <= '0;
                        r_row   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    if (!n_en || n_take) begin
                        if (n_en) begin
                            r_out.column      <= r_it.motor_index;
                            r_out.row         <= r_row;
                            r_out.coordinate  <= r_k;
                            r_out.coefficient <= n_val;
                            r_out.saturated   <= n_flag;
                            r_out.last        <= (n_hi[5:1] == '0);
                            r_row             <= r_row + 3'd1;
                        end
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'(NUM_COORDS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_row_le_coord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_out.row <= r_out.coordinate) else $error("row beyond coordinate");
    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_out.coordinate < 3'(NUM_COORDS)) else $error("bad coordinate");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_en && !n_take) |=> r_state == S_EMIT)
        else $error("emit left while output stalled");

endmodule

// ===== sv/rotor_mixer_column_core.sv =====
// per item, in order: the 48-step divider for R, the two 24-step cordic passes,
// 17 products on the one shared multiplier and six emit steps, one per coordinate
// whether enabled or not; an output stall holds the emit step
// a two-entry queue takes further items while the sequencer is busy
// reset: synchronous active low, clears control state, coord_enable returns to all six
// ----------------------------------------------------------------------------
// rotor_mixer_column_core
// Emits one motor's column of the multirotor mixer matrix, one row per beat.
// ----------------------------------------------------------------------------
module rotor_mixer_column_core #(
    parameter int MAX_MOTORS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [5:0]                          i_cfg_data,   // coord_enable
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // motor_index, kv, supply_voltage, full_scale, tilt_angle, azimuth_angle,
    // thrust_coef, drag_coef, spin_positive, pos_x, pos_y, pos_z, zero pad
    input  logic [rmc_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [rmc_pkg::OUT_TDATA_W-1:0]     o_m_tdata,    // column, row, coefficient, pad
    output logic [rmc_pkg::OUT_TUSER_W-1:0]     o_m_tuser,    // coordinate, saturated
    output logic                                o_m_tlast
);
    import rmc_pkg::*;

    t_coord_en r_coord_en;
    logic      w_q_valid;
    t_item     w_q_item;
    logic      w_pop;
    t_result   w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_en <= 6'h3f;
        end else if (i_cfg_valid) begin
            r_coord_en <= i_cfg_data;
        end
    end

    rmc_front #(.MAX_MOTORS(MAX_MOTORS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coord_en (r_coord_en),
        .i_valid    (i_s_tvalid),
        .i_data     (i_s_tdata),
        .o_ready    (o_s_tready),
        .o_valid    (w_q_valid),
        .o_item     (w_q_item),
        .i_pop      (w_pop)
    );

    rmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coord_en  (r_coord_en),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (o_m_tvalid),
        .o_out       (w_res),
        .i_out_ready (i_m_tready)
    );

    assign o_m_tdata = {1'b0, w_res.coefficient, w_res.row, w_res.column};
    assign o_m_tuser = {w_res.saturated, w_res.coordinate};
    assign o_m_tlast = w_res.last;

endmodule
